// ===== rtl/fcf_pkg.sv =====
// Package for the fully connected forward core.
// Holds sizes, load kinds, register indexes, state and pipeline tag types.
// No dependencies.
`default_nettype none

package fcf_pkg;

    localparam int OUT_MAX = 64;
    localparam int IN_MAX  = 256;

    localparam int ROW_W   = $clog2(OUT_MAX);
    localparam int COL_W   = $clog2(IN_MAX);
    localparam int WADDR_W = ROW_W + COL_W;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = PROD_W + COL_W;
    localparam int RES_W   = 32;
    localparam int OCNT_W  = 7;
    localparam int ICNT_W  = 9;
    localparam int CFG_W   = 9;
    localparam int KIND_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_ACT    = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam logic REG_OUT_COUNT = 1'b0;
    localparam logic REG_IN_COUNT  = 1'b1;

    localparam logic [OCNT_W-1:0] OUT_COUNT_RST = OCNT_W'(OUT_MAX);
    localparam logic [ICNT_W-1:0] IN_COUNT_RST  = ICNT_W'(IN_MAX);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last_col;
        logic             last_row;
        logic [ROW_W-1:0] row;
    } t_tag;

endpackage

`default_nettype wire

// ===== rtl/fcf_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Used for the weight, bias and activation stores. No dependencies.
`default_nettype none

module fcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/fcf_ctrl.sv =====
// Sequencer: walks rows and columns of the weight store, one MAC issue per cycle.
// Depends on fcf_pkg.
`default_nettype none

module fcf_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_trigger,
    input  wire logic                      i_done,
    input  wire logic [fcf_pkg::ROW_W-1:0] i_row_last,
    input  wire logic [fcf_pkg::COL_W-1:0] i_col_last,
    output logic                           o_busy,
    output logic [fcf_pkg::ROW_W-1:0]      o_row,
    output logic [fcf_pkg::COL_W-1:0]      o_col,
    output fcf_pkg::t_tag                  o_tag
);

    fcf_pkg::t_state            r_state, n_state;
    logic [fcf_pkg::ROW_W-1:0]  r_row, n_row;
    logic [fcf_pkg::COL_W-1:0]  r_col, n_col;
    fcf_pkg::t_tag              r_tag, n_tag;
    logic                       w_issue;
    logic                       w_end_col;
    logic                       w_end_row;

    assign w_end_col = (r_col == i_col_last);
    assign w_end_row = (r_row == i_row_last);

    always_comb begin
        n_state = r_state;
        case (r_state)
            fcf_pkg::ST_IDLE: begin
                if (i_trigger) n_state = fcf_pkg::ST_RUN;
            end
            fcf_pkg::ST_RUN: begin
                if (w_end_col && w_end_row) n_state = fcf_pkg::ST_DRAIN;
            end
            fcf_pkg::ST_DRAIN: begin
                if (i_done) n_state = fcf_pkg::ST_IDLE;
            end
            default: n_state = fcf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_issue = (r_state == fcf_pkg::ST_RUN);
        o_busy  = (r_state != fcf_pkg::ST_IDLE);
        n_row   = r_row;
        n_col   = r_col;
        if (r_state == fcf_pkg::ST_IDLE) begin
            n_row = '0;
            n_col = '0;
        end else if (w_issue) begin
            if (w_end_col) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        n_tag.vld      = w_issue;
        n_tag.first    = (r_col == '0);
        n_tag.last_col = w_end_col;
        n_tag.last_row = w_end_row;
        n_tag.row      = r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcf_pkg::ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_tag   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_tag   <= n_tag;
        end
    end

    assign o_row = r_row;
    assign o_col = r_col;
    assign o_tag = r_tag;

endmodule

`default_nettype wire

// ===== rtl/fcf_mac.sv =====
// Shared multiply-accumulate unit: product register, wide accumulator with bias,
// saturation to signed Q16.16 and the result register. Depends on fcf_pkg.
`default_nettype none

module fcf_mac (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire fcf_pkg::t_tag                    i_tag,
    input  wire logic signed [fcf_pkg::VAL_W-1:0] i_act,
    input  wire logic signed [fcf_pkg::VAL_W-1:0] i_weight,
    input  wire logic signed [fcf_pkg::VAL_W-1:0] i_bias,
    output logic                                  o_valid,
    output logic [fcf_pkg::ROW_W-1:0]             o_index,
    output logic signed [fcf_pkg::RES_W-1:0]      o_value,
    output logic                                  o_last
);

    localparam int SAT_W = fcf_pkg::ACC_W - fcf_pkg::RES_W + 1;

    fcf_pkg::t_tag                      r_tag2;
    logic signed [fcf_pkg::PROD_W-1:0]  r_prod;
    logic signed [fcf_pkg::VAL_W-1:0]   r_bias;
    logic signed [fcf_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic                               r_done;
    logic                               r_done_last;
    logic [fcf_pkg::ROW_W-1:0]          r_done_row;
    logic signed [fcf_pkg::RES_W-1:0]   n_sat;
    logic [SAT_W-1:0]                   w_top;

    always_comb begin
        if (r_tag2.first) begin
            n_acc = (fcf_pkg::ACC_W'(r_bias) <<< 8) + fcf_pkg::ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + fcf_pkg::ACC_W'(r_prod);
        end
    end

    assign w_top = r_acc[fcf_pkg::ACC_W-1:fcf_pkg::RES_W-1];

    always_comb begin
        if (w_top == '0 || w_top == '1) begin
            n_sat = r_acc[fcf_pkg::RES_W-1:0];
        end else if (r_acc[fcf_pkg::ACC_W-1]) begin
            n_sat = {1'b1, {(fcf_pkg::RES_W-1){1'b0}}};
        end else begin
            n_sat = {1'b0, {(fcf_pkg::RES_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_act * i_weight;
        r_bias <= i_bias;
        if (r_tag2.vld) begin
            r_acc <= n_acc;
        end
        r_done_row  <= r_tag2.row;
        r_done_last <= r_tag2.last_row;
        o_index     <= r_done_row;
        o_value     <= n_sat;
        o_last      <= r_done_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2  <= '0;
            r_done  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_tag2  <= i_tag;
            r_done  <= r_tag2.vld && r_tag2.last_col;
            o_valid <= r_done;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fully_connected_forward_core.sv =====
// Top level of the fully connected forward core: configuration registers,
// the three stores, the sequencer and the MAC unit.
// Depends on fcf_pkg, fcf_ram, fcf_ctrl and fcf_mac.
//
// Usage:
//   Input beats are taken when i_start is high and o_busy is low. i_kind selects
//   a weight load (row, col), a bias load (row) or an activation load (col);
//   kind 3 is dropped. Loads leave o_busy low.
//   An activation load at col = in_count-1 starts a vector: o_busy rises and
//   the core runs one MAC per cycle over out_count rows of in_count columns,
//   all through a single multiplier and accumulator.
//   Results come out one per row, each with o_valid high for one cycle, rows
//   in ascending order, o_last on the final row. o_busy falls in the cycle
//   after the final result. The run time of a vector is set by the one shared
//   MAC and the single read port of each store.
//   The receiver cannot stall: every o_valid beat is taken.
//   Configuration (index 0 out_count, index 1 in_count) is written through
//   i_cfg_we; write it only while idle, the core does not enforce it. Zero
//   counts act as 1, counts above the store size act as the store size.
//   Reset brings out_count to 64, in_count to 256 and the sequencer to idle.
//   The stores are not cleared; read only entries that were written.
`default_nettype none

module fully_connected_forward_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [fcf_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [fcf_pkg::ROW_W-1:0]        i_row_index,
    input  wire logic [fcf_pkg::COL_W-1:0]        i_col_index,
    input  wire logic signed [fcf_pkg::VAL_W-1:0] i_value,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_index,
    input  wire logic [fcf_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                                  o_valid,
    output logic [fcf_pkg::ROW_W-1:0]             o_out_index,
    output logic signed [fcf_pkg::RES_W-1:0]      o_out_value,
    output logic                                  o_last
);

    logic [fcf_pkg::OCNT_W-1:0]   r_out_count;
    logic [fcf_pkg::ICNT_W-1:0]   r_in_count;
    logic [fcf_pkg::ROW_W-1:0]    w_row_last;
    logic [fcf_pkg::COL_W-1:0]    w_col_last;
    logic                         w_accept;
    logic                         w_trigger;
    logic                         w_busy;
    logic [fcf_pkg::ROW_W-1:0]    w_rd_row;
    logic [fcf_pkg::COL_W-1:0]    w_rd_col;
    fcf_pkg::t_tag                w_tag;
    logic [fcf_pkg::VAL_W-1:0]    w_act;
    logic [fcf_pkg::VAL_W-1:0]    w_weight;
    logic [fcf_pkg::VAL_W-1:0]    w_bias;
    logic                         w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_count <= fcf_pkg::OUT_COUNT_RST;
            r_in_count  <= fcf_pkg::IN_COUNT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fcf_pkg::REG_OUT_COUNT) begin
                r_out_count <= i_cfg_data[fcf_pkg::OCNT_W-1:0];
            end else begin
                r_in_count <= i_cfg_data[fcf_pkg::ICNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_out_count == '0) begin
            w_row_last = '0;
        end else if (r_out_count > fcf_pkg::OCNT_W'(fcf_pkg::OUT_MAX)) begin
            w_row_last = fcf_pkg::ROW_W'(fcf_pkg::OUT_MAX - 1);
        end else begin
            w_row_last = fcf_pkg::ROW_W'(r_out_count - 1'b1);
        end
        if (r_in_count == '0) begin
            w_col_last = '0;
        end else if (r_in_count > fcf_pkg::ICNT_W'(fcf_pkg::IN_MAX)) begin
            w_col_last = fcf_pkg::COL_W'(fcf_pkg::IN_MAX - 1);
        end else begin
            w_col_last = fcf_pkg::COL_W'(r_in_count - 1'b1);
        end
    end

    assign w_accept  = i_start && !w_busy;
    assign w_trigger = w_accept && (i_kind == fcf_pkg::KIND_ACT) &&
                       (i_col_index == w_col_last);

    fcf_ram #(.WIDTH(fcf_pkg::VAL_W), .DEPTH(fcf_pkg::OUT_MAX * fcf_pkg::IN_MAX)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_kind == fcf_pkg::KIND_WEIGHT)),
        .i_waddr ({i_row_index, i_col_index}),
        .i_wdata (i_value),
        .i_raddr ({w_rd_row, w_rd_col}),
        .o_rdata (w_weight)
    );

    fcf_ram #(.WIDTH(fcf_pkg::VAL_W), .DEPTH(fcf_pkg::OUT_MAX)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_kind == fcf_pkg::KIND_BIAS)),
        .i_waddr (i_row_index),
        .i_wdata (i_value),
        .i_raddr (w_rd_row),
        .o_rdata (w_bias)
    );

    fcf_ram #(.WIDTH(fcf_pkg::VAL_W), .DEPTH(fcf_pkg::IN_MAX)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_kind == fcf_pkg::KIND_ACT)),
        .i_waddr (i_col_index),
        .i_wdata (i_value),
        .i_raddr (w_rd_col),
        .o_rdata (w_act)
    );

    fcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_trigger  (w_trigger),
        .i_done     (w_done),
        .i_row_last (w_row_last),
        .i_col_last (w_col_last),
        .o_busy     (w_busy),
        .o_row      (w_rd_row),
        .o_col      (w_rd_col),
        .o_tag      (w_tag)
    );

    fcf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_tag),
        .i_act    (w_act),
        .i_weight (w_weight),
        .i_bias   (w_bias),
        .o_valid  (o_valid),
        .o_index  (o_out_index),
        .o_value  (o_out_value),
        .o_last   (o_last)
    );

    assign w_done = o_valid && o_last;
    assign o_busy = w_busy;

endmodule

`default_nettype wire

// ===== rtl/fcf_checker.sv =====
// Port-level checker for the fully connected forward core, with its bind.
// Depends on fully_connected_forward_core's port list and fcf_pkg.
`default_nettype none

module fcf_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       o_busy,
    input  wire logic [fcf_pkg::KIND_W-1:0] i_kind,
    input  wire logic                       o_valid,
    input  wire logic                       o_last
);

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result beat while idle");

    a_busy_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_busy)
        else $error("busy dropped before final result");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_busy)
        else $error("busy held after final result");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start && (i_kind == fcf_pkg::KIND_ACT)))
        else $error("busy raised without an activation beat");

endmodule

bind fully_connected_forward_core fcf_checker u_fcf_checker (.*);

`default_nettype wire

// ===== tb/tb_fully_connected_forward_core.sv =====
// Testbench for fully_connected_forward_core: queued load beats, a bursty driver,
// a predictor of the layer outputs and a monitor that checks every result beat.
// Depends on fcf_pkg and the fully_connected_forward_core RTL.
`timescale 1ns / 1ps

module tb_fully_connected_forward_core;

    localparam int     LIMIT  = 400000;
    localparam longint SAT_HI = 2147483647;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        fcf_pkg::t_kind                   kind;
        logic [fcf_pkg::ROW_W-1:0]        row;
        logic [fcf_pkg::COL_W-1:0]        col;
        logic signed [fcf_pkg::VAL_W-1:0] val;
    } t_load;

    typedef struct packed {
        logic [fcf_pkg::ROW_W-1:0]        idx;
        logic signed [fcf_pkg::RES_W-1:0] val;
        logic                             last;
    } t_neuron_out;

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             i_start     = 1'b0;
    logic [fcf_pkg::KIND_W-1:0]       i_kind      = '0;
    logic [fcf_pkg::ROW_W-1:0]        i_row_index = '0;
    logic [fcf_pkg::COL_W-1:0]        i_col_index = '0;
    logic signed [fcf_pkg::VAL_W-1:0] i_value     = '0;
    logic                             i_cfg_we    = 1'b0;
    logic                             i_cfg_index = 1'b0;
    logic [fcf_pkg::CFG_W-1:0]        i_cfg_data  = '0;
    logic                             o_busy;
    logic                             o_valid;
    logic [fcf_pkg::ROW_W-1:0]        o_out_index;
    logic signed [fcf_pkg::RES_W-1:0] o_out_value;
    logic                             o_last;

    fully_connected_forward_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_kind      (i_kind),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    // layer state as the core should hold it
    logic signed [fcf_pkg::VAL_W-1:0] weight_mem [fcf_pkg::OUT_MAX*fcf_pkg::IN_MAX];
    logic signed [fcf_pkg::VAL_W-1:0] bias_mem   [fcf_pkg::OUT_MAX];
    logic signed [fcf_pkg::VAL_W-1:0] act_mem    [fcf_pkg::IN_MAX];
    logic [fcf_pkg::OCNT_W-1:0]       cfg_out = fcf_pkg::OUT_COUNT_RST;
    logic [fcf_pkg::ICNT_W-1:0]       cfg_in  = fcf_pkg::IN_COUNT_RST;

    // entries written by the beats already queued
    bit weight_loaded [fcf_pkg::OUT_MAX*fcf_pkg::IN_MAX];
    bit bias_loaded   [fcf_pkg::OUT_MAX];
    bit act_loaded    [fcf_pkg::IN_MAX];

    t_load       pending_loads [$];
    t_neuron_out expected_outputs [$];
    t_load       cur_load;

    int errors     = 0;
    int n_queued   = 0;
    int n_beats    = 0;
    int n_results  = 0;
    int n_vectors  = 0;
    int cycles     = 0;
    int burst_left = 0;
    int gap_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(int v, int max);
        if (v == 0) return 1;
        if (v > max) return max;
        return v;
    endfunction

    function automatic logic signed [fcf_pkg::VAL_W-1:0] rand_val();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return '1;
            default: return fcf_pkg::VAL_W'($urandom);
        endcase
    endfunction

    task automatic apply_load(t_load ld);
        int n_out, n_in;
        longint acc;
        t_neuron_out r;
        n_out = clamp_dim(cfg_out, fcf_pkg::OUT_MAX);
        n_in  = clamp_dim(cfg_in, fcf_pkg::IN_MAX);
        case (ld.kind)
            fcf_pkg::KIND_WEIGHT: weight_mem[{ld.row, ld.col}] = ld.val;
            fcf_pkg::KIND_BIAS:   bias_mem[ld.row] = ld.val;
            fcf_pkg::KIND_ACT: begin
                act_mem[ld.col] = ld.val;
                if (int'(ld.col) == n_in - 1) begin
                    n_vectors++;
                    for (int i = 0; i < n_out; i++) begin
                        acc = 0;
                        for (int d = 0; d < n_in; d++)
                            acc += longint'(act_mem[d]) *
                                   longint'(weight_mem[i*fcf_pkg::IN_MAX + d]);
                        acc += longint'(bias_mem[i]) * 256;
                        if (acc > SAT_HI) acc = SAT_HI;
                        if (acc < SAT_LO) acc = SAT_LO;
                        r.idx  = fcf_pkg::ROW_W'(i);
                        r.val  = acc[31:0];
                        r.last = (i == n_out - 1);
                        expected_outputs.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_raw(fcf_pkg::t_kind kind, int row, int col,
                            logic signed [fcf_pkg::VAL_W-1:0] v);
        t_load ld;
        ld.kind = kind;
        ld.row  = fcf_pkg::ROW_W'(row);
        ld.col  = fcf_pkg::COL_W'(col);
        ld.val  = v;
        pending_loads.push_back(ld);
        n_queued++;
        case (kind)
            fcf_pkg::KIND_WEIGHT: weight_loaded[{ld.row, ld.col}] = 1'b1;
            fcf_pkg::KIND_BIAS:   bias_loaded[ld.row] = 1'b1;
            fcf_pkg::KIND_ACT:    act_loaded[ld.col] = 1'b1;
            default: ;
        endcase
    endtask

    // a trigger beat is preceded by loads of every entry the vector reads
    task automatic queue_load(fcf_pkg::t_kind kind, int row, int col,
                              logic signed [fcf_pkg::VAL_W-1:0] v);
        int n_out, n_in;
        n_out = clamp_dim(cfg_out, fcf_pkg::OUT_MAX);
        n_in  = clamp_dim(cfg_in, fcf_pkg::IN_MAX);
        if (kind == fcf_pkg::KIND_ACT && col == n_in - 1) begin
            for (int r = 0; r < n_out; r++) begin
                for (int c = 0; c < n_in; c++)
                    if (!weight_loaded[r*fcf_pkg::IN_MAX + c])
                        push_raw(fcf_pkg::KIND_WEIGHT, r, c, rand_val());
                if (!bias_loaded[r]) push_raw(fcf_pkg::KIND_BIAS, r, 0, rand_val());
            end
            for (int c = 0; c < n_in - 1; c++)
                if (!act_loaded[c]) push_raw(fcf_pkg::KIND_ACT, 0, c, rand_val());
        end
        push_raw(kind, row, col, v);
    endtask

    task automatic wait_quiet();
        while (pending_loads.size() != 0 || i_start || expected_outputs.size() != 0 || o_busy)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_dims(logic [fcf_pkg::CFG_W-1:0] out_data,
                            logic [fcf_pkg::CFG_W-1:0] in_data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fcf_pkg::REG_OUT_COUNT;
        i_cfg_data  <= out_data;
        cfg_out      = out_data[fcf_pkg::OCNT_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= fcf_pkg::REG_IN_COUNT;
        i_cfg_data  <= in_data;
        cfg_in       = in_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // n_items counts every queued beat, fill loads included
    task automatic run_random(logic [fcf_pkg::CFG_W-1:0] out_data,
                              logic [fcf_pkg::CFG_W-1:0] in_data, int n_items);
        int n_out, n_in, base, k;
        fcf_pkg::t_kind kd;
        wait_quiet();
        set_dims(out_data, in_data);
        n_out = clamp_dim(cfg_out, fcf_pkg::OUT_MAX);
        n_in  = clamp_dim(cfg_in, fcf_pkg::IN_MAX);
        base  = n_queued;
        while (n_queued - base < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                kd = fcf_pkg::t_kind'($urandom_range(0, 3));
                queue_load(kd, $urandom_range(0, fcf_pkg::OUT_MAX-1),
                           $urandom_range(0, fcf_pkg::IN_MAX-1), rand_val());
            end else if (n_in <= 16 && $urandom_range(0, 3) == 0) begin
                for (int c = 0; c < n_in; c++)
                    queue_load(fcf_pkg::KIND_ACT, $urandom_range(0, fcf_pkg::OUT_MAX-1), c,
                               rand_val());
            end else begin
                k = $urandom_range(0, 5);
                repeat (k) begin
                    kd = fcf_pkg::t_kind'($urandom_range(0, 2));
                    if (kd == fcf_pkg::KIND_ACT && n_in == 1) kd = fcf_pkg::KIND_WEIGHT;
                    queue_load(kd, $urandom_range(0, n_out-1),
                               (kd == fcf_pkg::KIND_ACT) ? $urandom_range(0, n_in-2)
                                                         : $urandom_range(0, n_in-1),
                               rand_val());
                end
                queue_load(fcf_pkg::KIND_ACT, $urandom_range(0, fcf_pkg::OUT_MAX-1), n_in-1,
                           rand_val());
            end
        end
    endtask

    // driver: bursts of beats with random gaps, hold while busy
    always @(posedge i_clk) begin
        logic take;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            take = i_start && !o_busy;
            if (take) begin
                apply_load(cur_load);
                n_beats++;
            end
            if (i_start && !take) begin
            end else if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (pending_loads.size() > 0) begin
                cur_load = pending_loads.pop_front();
                i_kind      <= cur_load.kind;
                i_row_index <= cur_load.row;
                i_col_index <= cur_load.col;
                i_value     <= cur_load.val;
                i_start     <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(0, 10);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_neuron_out e;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (expected_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat index %0d value %0d last %0b",
                         $time, o_out_index, o_out_value, o_last);
            end else begin
                e = expected_outputs.pop_front();
                if (o_out_index !== e.idx || o_out_value !== e.val || o_last !== e.last) begin
                    errors++;
                    $display("%0t: mismatch expected index %0d value %0d last %0b,",
                             $time, e.idx, e.val, e.last);
                    $display("%0t:          got index %0d value %0d last %0b",
                             $time, o_out_index, o_out_value, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero counts act as one output of one input
        set_dims('0, '0);
        queue_load(fcf_pkg::KIND_WEIGHT, 0, 0, 16'sh8000);
        queue_load(fcf_pkg::KIND_BIAS, 0, 0, 16'sh7FFF);
        queue_load(fcf_pkg::KIND_ACT, 0, 0, 16'sh8000);
        queue_load(fcf_pkg::KIND_NONE, fcf_pkg::OUT_MAX-1, fcf_pkg::IN_MAX-1, '1);
        queue_load(fcf_pkg::KIND_WEIGHT, fcf_pkg::OUT_MAX-1, fcf_pkg::IN_MAX-1, 16'sh7FFF);
        queue_load(fcf_pkg::KIND_BIAS, fcf_pkg::OUT_MAX-1, 0, 16'sh8000);
        queue_load(fcf_pkg::KIND_ACT, fcf_pkg::OUT_MAX-1, fcf_pkg::IN_MAX-1, 16'sh7FFF);
        queue_load(fcf_pkg::KIND_ACT, fcf_pkg::OUT_MAX-1, 0, 16'sh7FFF);

        // saturation both ways and an exact midrange sum
        wait_quiet();
        set_dims(9'd3, 9'd2);
        queue_load(fcf_pkg::KIND_WEIGHT, 0, 0, 16'sh7FFF);
        queue_load(fcf_pkg::KIND_WEIGHT, 0, 1, 16'sh7FFF);
        queue_load(fcf_pkg::KIND_WEIGHT, 1, 0, 16'sh8000);
        queue_load(fcf_pkg::KIND_WEIGHT, 1, 1, 16'sh8000);
        queue_load(fcf_pkg::KIND_WEIGHT, 2, 0, 16'sh8000);
        queue_load(fcf_pkg::KIND_WEIGHT, 2, 1, 16'sh7FFF);
        queue_load(fcf_pkg::KIND_BIAS, 0, 0, 16'sh8000);
        queue_load(fcf_pkg::KIND_BIAS, 1, 0, 16'sh7FFF);
        queue_load(fcf_pkg::KIND_BIAS, 2, 0, '0);
        queue_load(fcf_pkg::KIND_ACT, 0, 0, 16'sh8000);
        queue_load(fcf_pkg::KIND_ACT, 0, 1, 16'sh8000);
        queue_load(fcf_pkg::KIND_ACT, 5, 1, 16'sh7FFF);

        run_random(9'h1FF, 9'd1, 140);
        run_random(9'd8, 9'd8, 100);
        run_random(9'd9, 9'd13, 90);
        run_random(9'd0, 9'd24, 60);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d load beats, %0d vectors, %0d result beats checked",
                 n_beats, n_vectors, n_results);
        $display("Shapes 1x1, 3x2, 64x1, 8x8, 9x13, 1x24, with saturation and count clamps");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
